// ===== rtl/b10k_pkg.sv =====
// Shared types and constants for the base-10000 dot product block.
`default_nettype none
package b10k_pkg;

	typedef logic [13:0] digit_t;
	typedef logic [15:0] high_t;
	typedef logic [27:0] prod_t;
	typedef logic [31:0] acc_t;
	typedef logic [15:0] wrap_t;
	typedef logic [18:0] quo4_t;
	typedef logic [4:0]  quo8_t;

	localparam acc_t  ACC_LIMIT     = 32'd3000000000;
	localparam digit_t RADIX        = 14'd10000;
	localparam quo8_t HIGH_PER_WRAP = 5'd30;

	// floor(a / 10000) = (a * RECIP_Q4) >> Q4_SHIFT for any 32-bit a.
	localparam logic [31:0] RECIP_Q4 = 32'hD1B71759;
	localparam int          Q4_SHIFT = 45;

	// floor(n / 10000) = (n * RECIP_Q8) >> Q8_SHIFT for n below 300000.
	localparam logic [18:0] RECIP_Q8 = 19'd429497;
	localparam int          Q8_SHIFT = 32;

endpackage
`default_nettype wire

// ===== rtl/base10000_dot_product.sv =====
// Streaming dot product of base-10000 digit vectors with a three-digit result.
//
// Each request carries one digit pair; while in_stall is low the block takes one request
// per clock cycle, multiplies the pair in the first stage and adds it into a running sum
// that is kept below 3000000000 by a wrap counter. The request marked last_term closes
// the vector: its total is split into three base-10000 digits over three further stages,
// and the result passes through s2, s3, s4 and the output register. The accumulate stage,
// a 32-bit add with one compare and subtract, is the loop that bounds the clock rate. A
// waiting result only holds the stages behind it, so pairs of the next vector keep flowing
// in; the input stalls only once four finished results wait in s2 and the split stages
// and the last pair of a fifth vector has reached the accumulate stage.
`default_nettype none
module base10000_dot_product (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  wire b10k_pkg::digit_t x_digit,
	input  wire b10k_pkg::digit_t y_digit,
	input  wire            last_term,
	output logic           out_valid,
	input  wire            out_stall,
	output b10k_pkg::digit_t digit_low,
	output b10k_pkg::digit_t digit_mid,
	output b10k_pkg::high_t  digit_high
);
	import b10k_pkg::*;

	logic   vld_s1, vld_s2, vld_s3, vld_s4, out_valid_q;
	logic   adv1, adv2, adv3, adv4, adv5, take1;
	prod_t  prod_s1;
	logic   last_s1;
	acc_t   acc_q;
	wrap_t  wrap_q;
	acc_t   sum;
	logic [32:0] diff;
	acc_t   acc_next;
	wrap_t  wrap_next;
	acc_t   acc_s2;
	wrap_t  wrap_s2;
	logic [63:0] q4_prod;
	quo4_t  q4_s3;
	digit_t acclo_s3;
	wrap_t  wrap_s3;
	logic [32:0] q4_scaled;
	logic [37:0] q8_prod;
	digit_t low_s4;
	digit_t q4lo_s4;
	quo8_t  q8_s4;
	wrap_t  wrap_s4;
	logic [18:0] q8_scaled;
	logic [20:0] wrap_scaled;
	digit_t digit_low_q, digit_mid_q;
	high_t  digit_high_q;

	assign adv5  = !out_valid_q || !out_stall;
	assign adv4  = !vld_s4 || adv5;
	assign adv3  = !vld_s3 || adv4;
	assign adv2  = !vld_s2 || adv3;
	assign take1 = vld_s1 && (!last_s1 || adv2);
	assign adv1  = !vld_s1 || take1;
	assign in_stall = !adv1;

	assign sum  = acc_q + 32'(prod_s1);
	assign diff = {1'b0, sum} - {1'b0, ACC_LIMIT};

	always_comb begin
		if (!diff[32]) begin
			acc_next  = diff[31:0];
			wrap_next = wrap_q + 16'd1;
		end else begin
			acc_next  = sum;
			wrap_next = wrap_q;
		end
	end

	assign q4_prod     = 64'(acc_s2) * 64'(RECIP_Q4);
	assign q4_scaled   = 33'(q4_s3) * 33'(RADIX);
	assign q8_prod     = 38'(q4_s3) * 38'(RECIP_Q8);
	assign q8_scaled   = 19'(q8_s4) * 19'(RADIX);
	assign wrap_scaled = 21'(wrap_s4) * 21'(HIGH_PER_WRAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			wrap_q      <= '0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (take1) begin
				if (last_s1) begin
					acc_q  <= '0;
					wrap_q <= '0;
				end else begin
					acc_q  <= acc_next;
					wrap_q <= wrap_next;
				end
			end
			if (adv2) vld_s2 <= take1 && last_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) out_valid_q <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			prod_s1 <= 28'(x_digit) * 28'(y_digit);
			last_s1 <= last_term;
		end
		if (adv2) begin
			acc_s2  <= acc_next;
			wrap_s2 <= wrap_next;
		end
		if (adv3) begin
			q4_s3    <= q4_prod[Q4_SHIFT+18:Q4_SHIFT];
			acclo_s3 <= acc_s2[13:0];
			wrap_s3  <= wrap_s2;
		end
		if (adv4) begin
			low_s4  <= acclo_s3 - q4_scaled[13:0];
			q4lo_s4 <= q4_s3[13:0];
			q8_s4   <= q8_prod[Q8_SHIFT+4:Q8_SHIFT];
			wrap_s4 <= wrap_s3;
		end
		if (adv5 && vld_s4) begin
			digit_low_q  <= low_s4;
			digit_mid_q  <= q4lo_s4 - q8_scaled[13:0];
			digit_high_q <= wrap_scaled[15:0] + 16'(q8_s4);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_low  = digit_low_q;
	assign digit_mid  = digit_mid_q;
	assign digit_high = digit_high_q;

`ifndef SYNTH
	// The running sum never reaches the wrap limit.
	a_acc_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < ACC_LIMIT)
		else $error("accumulator reached the wrap limit");

	// Closing a vector clears the running state.
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		take1 && last_s1 |=> acc_q == '0 && wrap_q == '0)
		else $error("state not cleared after the last pair");

	// A new result only appears when the final split stage held one.
	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_s4))
		else $error("result without a finished split");

	// The low and middle digits are proper base-10000 digits.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> digit_low < RADIX && digit_mid < RADIX)
		else $error("result digit out of range");

	// Input is only held back while a last pair waits for the split stages.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && last_s1 && vld_s2)
		else $error("input stalled without a waiting result");
`endif

endmodule
`default_nettype wire
